@@ rtl/blst_pkg.sv @@
// blst_pkg: shared types and codes for the bounded list store
// transaction structs, request and status codes, controller states, cell control
// no dependencies
`timescale 1ns / 1ps

package blst_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int REQ_W        = 2;
  localparam int STAT_W       = 2;
  localparam int OUT_CNT_W    = 9;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } blst_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [OUT_CNT_W-1:0]     element_count;
  } blst_rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_REMOVE
  } blst_state_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic wr;     // load wr_value into the addressed cell
    logic shift;  // cells at or after addr take their right neighbor
  } blst_cell_ctrl_t;

endpackage

@@ rtl/blst_cell.sv @@
// blst_cell: one storage cell of the list row, holds a single element
// depends on blst_pkg for the cell control struct and data width
`timescale 1ns / 1ps

module blst_cell #(
  parameter int IDX_W = 8,
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  blst_pkg::blst_cell_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]              addr,
  input  logic [blst_pkg::DATA_W-1:0]   wr_value,
  input  logic [blst_pkg::DATA_W-1:0]   nbr_data,
  output logic [blst_pkg::DATA_W-1:0]   data,
  output logic [blst_pkg::DATA_W-1:0]   tap
);

  logic sel;
  logic at_or_after;

  assign sel         = (addr == IDX_W'(INDEX));
  assign at_or_after = (addr <= IDX_W'(INDEX));

  always_ff @(posedge clk) begin
    if (ctrl.wr && sel) begin
      data <= wr_value;
    end else if (ctrl.shift && at_or_after) begin
      data <= nbr_data;
    end
  end

  // zero unless addressed, so the row can simply or the taps together
  assign tap = sel ? data : '0;

endmodule

@@ rtl/blst_chain.sv @@
// blst_chain: row of list cells, each linked to its right neighbor for compaction
// depends on blst_pkg and blst_cell
`timescale 1ns / 1ps

module blst_chain #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic                          clk,
  input  blst_pkg::blst_cell_ctrl_t     ctrl,
  input  logic [IDX_W-1:0]              addr,
  input  logic [blst_pkg::DATA_W-1:0]   wr_value,
  output logic [blst_pkg::DATA_W-1:0]   sel_data
);

  logic [blst_pkg::DATA_W-1:0] data [CAPACITY];
  logic [blst_pkg::DATA_W-1:0] taps [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [blst_pkg::DATA_W-1:0] nbr;
    // last cell has no neighbor; what it takes lies beyond the count
    if (i == CAPACITY - 1) begin : g_last
      assign nbr = data[i];
    end else begin : g_mid
      assign nbr = data[i+1];
    end

    blst_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .addr     (addr),
      .wr_value (wr_value),
      .nbr_data (nbr),
      .data     (data[i]),
      .tap      (taps[i])
    );
  end

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data = sel_data | taps[i];
    end
  end

endmodule

@@ rtl/bounded_list_store_core.sv @@
// bounded_list_store_core: append, read and write are done when accepted, result registered
// into the response buffer; remove-all scans the cell row, stepping past each kept element and
// shifting the row left over each match, and holds intake stalled meanwhile.
// a two-entry response buffer lets one transaction be taken while a result waits.
// rst clears the count, controller and response buffer; cell contents are not reset.
`timescale 1ns / 1ps

module bounded_list_store_core #(
  parameter int CAPACITY = blst_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  blst_pkg::blst_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output blst_pkg::blst_rsp_t rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > blst_pkg::POS_W) ? CNT_W : blst_pkg::POS_W;

  blst_pkg::blst_state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic [blst_pkg::DATA_W-1:0] rm_value, rm_value_next;

  blst_pkg::blst_cell_ctrl_t   cell_ctrl;
  logic [IDX_W-1:0]            addr;
  logic [blst_pkg::DATA_W-1:0] wr_value;
  logic [blst_pkg::DATA_W-1:0] sel_data;

  logic                accept;
  logic                res_valid;
  blst_pkg::blst_rsp_t res;
  logic [CMP_W-1:0]    pos_ext;
  logic                in_range;

  logic                skid_valid;
  blst_pkg::blst_rsp_t skid;
  logic                take;

  blst_chain #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_chain (
    .clk      (clk),
    .ctrl     (cell_ctrl),
    .addr     (addr),
    .wr_value (wr_value),
    .sel_data (sel_data)
  );

  assign req_stall = (state != blst_pkg::ST_IDLE) || skid_valid;
  assign accept    = req_valid && !req_stall;
  assign pos_ext   = CMP_W'(req.position);
  assign in_range  = pos_ext < CMP_W'(count);

  always_comb begin
    state_next    = state;
    count_next    = count;
    ptr_next      = ptr;
    rm_value_next = rm_value;
    cell_ctrl     = '0;
    addr          = pos_ext[IDX_W-1:0];
    wr_value      = req.item_value;
    res_valid     = 1'b0;
    res           = '0;
    res.status    = blst_pkg::STAT_OK;

    case (state)
      blst_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            blst_pkg::REQ_APPEND: begin
              addr      = count[IDX_W-1:0];
              res_valid = 1'b1;
              if (count >= CNT_W'(CAPACITY)) begin
                res.status = blst_pkg::STAT_FULL;
              end else begin
                cell_ctrl.wr = 1'b1;
                count_next   = count + 1'b1;
              end
            end
            blst_pkg::REQ_REMOVE: begin
              state_next    = blst_pkg::ST_REMOVE;
              ptr_next      = '0;
              rm_value_next = req.item_value;
            end
            blst_pkg::REQ_READ: begin
              res_valid = 1'b1;
              if (in_range) begin
                res.read_value = sel_data;
              end else begin
                res.status = blst_pkg::STAT_RANGE;
              end
            end
            blst_pkg::REQ_WRITE: begin
              res_valid = 1'b1;
              if (in_range) begin
                cell_ctrl.wr = 1'b1;
              end else begin
                res.status = blst_pkg::STAT_RANGE;
              end
            end
            default: begin
              res_valid = 1'b0;
            end
          endcase
        end
      end
      blst_pkg::ST_REMOVE: begin
        addr = ptr[IDX_W-1:0];
        if (ptr >= count) begin
          // scan done, report once the response buffer has room
          if (!skid_valid) begin
            res_valid  = 1'b1;
            state_next = blst_pkg::ST_IDLE;
          end
        end else if (sel_data == rm_value) begin
          // drop the match: everything from ptr on moves one cell left
          cell_ctrl.shift = 1'b1;
          count_next      = count - 1'b1;
        end else begin
          ptr_next = ptr + 1'b1;
        end
      end
      default: begin
        state_next = blst_pkg::ST_IDLE;
      end
    endcase

    res.element_count = blst_pkg::OUT_CNT_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= blst_pkg::ST_IDLE;
      count <= '0;
      ptr   <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    rm_value <= rm_value_next;
  end

  // response buffer: output register plus one skid entry
  assign take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        rsp        <= skid;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!rsp_valid || take) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      rsp_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == blst_pkg::ST_REMOVE) |-> (ptr <= count))
    else $error("remove scan pointer passed the count");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid entry held with empty output register");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == blst_pkg::ST_REMOVE) |=> (count <= $past(count)))
    else $error("count grew during remove");

endmodule

@@ verif/tb_bounded_list_store_core.sv @@
// tb_bounded_list_store_core: self-checking bench for the bounded list store core
// directed table then phased random traffic, checked against the table's expected responses or an in-bench list model
// depends on blst_pkg and bounded_list_store_core
`timescale 1ns / 1ps

module tb_bounded_list_store_core;

  localparam int LIST_CAP    = blst_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int TAIL_CYCLES = LIST_CAP + 40;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_REPORTS = 10;

  localparam int IDLE_NONE   = 0;
  localparam int IDLE_FULL   = 1;
  localparam int IDLE_SPARSE = 2;

  localparam int STYLE_MIX  = 0;
  localparam int STYLE_FILL = 1;

  typedef struct packed {
    logic [blst_pkg::REQ_W-1:0]     op;
    logic [blst_pkg::POS_W-1:0]     pos;
    logic [blst_pkg::DATA_W-1:0]    val;
    bit                             typed;
    logic [blst_pkg::DATA_W-1:0]    rd;
    logic [blst_pkg::STAT_W-1:0]    st;
    logic [blst_pkg::OUT_CNT_W-1:0] cnt;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIRECTED [DIR_N] = '{
    '{blst_pkg::REQ_READ,   8'd0,   32'h0000_0000,
      1'b1, 32'h0000_0000, blst_pkg::STAT_RANGE, 9'd0},
    '{blst_pkg::REQ_WRITE,  8'd0,   32'h0000_0005,
      1'b1, 32'h0000_0000, blst_pkg::STAT_RANGE, 9'd0},
    '{blst_pkg::REQ_REMOVE, 8'd0,   32'h0000_0000,
      1'b1, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_APPEND, 8'hFF,  32'h8000_0000,
      1'b1, 32'h0000_0000, blst_pkg::STAT_OK,    9'd1},
    '{blst_pkg::REQ_APPEND, 8'd0,   32'h7FFF_FFFF,
      1'b1, 32'h0000_0000, blst_pkg::STAT_OK,    9'd2},
    '{blst_pkg::REQ_APPEND, 8'h5A,  32'h0000_0000,
      1'b1, 32'h0000_0000, blst_pkg::STAT_OK,    9'd3},
    '{blst_pkg::REQ_APPEND, 8'd0,   32'hFFFF_FFFF,
      1'b1, 32'h0000_0000, blst_pkg::STAT_OK,    9'd4},
    '{blst_pkg::REQ_READ,   8'd0,   32'h0000_0000,
      1'b1, 32'h8000_0000, blst_pkg::STAT_OK,    9'd4},
    '{blst_pkg::REQ_READ,   8'd1,   32'hFFFF_FFFF,
      1'b1, 32'h7FFF_FFFF, blst_pkg::STAT_OK,    9'd4},
    '{blst_pkg::REQ_READ,   8'd4,   32'h0000_0000,
      1'b1, 32'h0000_0000, blst_pkg::STAT_RANGE, 9'd4},
    '{blst_pkg::REQ_READ,   8'd255, 32'h0000_0000,
      1'b1, 32'h0000_0000, blst_pkg::STAT_RANGE, 9'd4},
    '{blst_pkg::REQ_WRITE,  8'd255, 32'h0000_0007,
      1'b1, 32'h0000_0000, blst_pkg::STAT_RANGE, 9'd4},
    '{blst_pkg::REQ_WRITE,  8'd3,   32'h7FFF_FFFF,
      1'b1, 32'h0000_0000, blst_pkg::STAT_OK,    9'd4},
    '{blst_pkg::REQ_REMOVE, 8'd0,   32'h7FFF_FFFF,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_READ,   8'd1,   32'h0000_0000,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_REMOVE, 8'hA5,  32'h0001_2345,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_APPEND, 8'd0,   32'hA5A5_A5A5,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_APPEND, 8'd0,   32'h5A5A_5A5A,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_WRITE,  8'd0,   32'h1234_5678,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_READ,   8'd0,   32'h0000_0000,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_REMOVE, 8'd0,   32'h8000_0000,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_READ,   8'd3,   32'h0000_0000,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_REMOVE, 8'd0,   32'h0000_0000,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0},
    '{blst_pkg::REQ_READ,   8'd2,   32'h0000_0000,
      1'b0, 32'h0000_0000, blst_pkg::STAT_OK,    9'd0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  blst_pkg::blst_req_t req = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  blst_pkg::blst_rsp_t rsp;

  // list model state, updated as each request transaction is accepted
  logic [blst_pkg::DATA_W-1:0] shadow_elems [LIST_CAP];
  int                          shadow_count = 0;

  blst_pkg::blst_rsp_t pending_rsp [$];
  int        mismatches    = 0;
  int        cycle_count   = 0;
  int        tx_mode       = IDLE_FULL;
  int        rx_mode       = IDLE_FULL;
  int        rx_wait       = 0;
  int        rx_hold       = 0;
  int        rx_cycles     = 0;
  int        hold_requests = 0;
  int        holds_done    = 0;

  bounded_list_store_core #(.CAPACITY(LIST_CAP)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #10 clk = ~clk;

  function automatic blst_pkg::blst_rsp_t list_step(input blst_pkg::blst_req_t r);
    blst_pkg::blst_rsp_t o;
    int                  kept;
    o = '0;
    o.status = blst_pkg::STAT_OK;
    case (r.req_type)
      blst_pkg::REQ_APPEND: begin
        if (shadow_count >= LIST_CAP) begin
          o.status = blst_pkg::STAT_FULL;
        end else begin
          shadow_elems[shadow_count] = r.item_value;
          shadow_count++;
        end
      end
      blst_pkg::REQ_REMOVE: begin
        kept = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_elems[i] != r.item_value) begin
            shadow_elems[kept] = shadow_elems[i];
            kept++;
          end
        end
        shadow_count = kept;
      end
      default: begin
        if (int'(r.position) >= shadow_count) begin
          o.status = blst_pkg::STAT_RANGE;
        end else if (r.req_type == blst_pkg::REQ_READ) begin
          o.read_value = shadow_elems[r.position];
        end else begin
          shadow_elems[r.position] = r.item_value;
        end
      end
    endcase
    o.element_count = shadow_count[blst_pkg::OUT_CNT_W-1:0];
    return o;
  endfunction

  function automatic int pick_idle(input int mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      default:     return $urandom_range(0, 18);
    endcase
  endfunction

  // small signed pool most of the time so removes find matches
  function automatic logic [blst_pkg::DATA_W-1:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return blst_pkg::DATA_W'(int'($urandom_range(0, 7)) - 4);
      6, 7, 8:          return $urandom;
      default:          return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic send_request(input blst_pkg::blst_req_t item, input bit typed,
                              input blst_pkg::blst_rsp_t typed_rsp);
    int                  gap;
    blst_pkg::blst_rsp_t predicted;
    gap = pick_idle(tx_mode);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = list_step(item);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  // response side: random stall per transaction, plus a long hold-off on request
  always @(posedge clk) begin : rsp_side
    blst_pkg::blst_rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 400 == 0) rx_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected response: read_value %h status %0d count %0d",
                     rsp.read_value, rsp.status, rsp.element_count);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.read_value !== want.read_value || rsp.status !== want.status ||
              rsp.element_count !== want.element_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: rd exp %h got %h, st exp %0d got %0d, cnt exp %0d got %0d",
                       want.read_value, rsp.read_value, want.status, rsp.status,
                       want.element_count, rsp.element_count);
          end
        end
        rx_wait = pick_idle(rx_mode);
      end
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        rx_hold    = HOLD_CYCLES;
      end
      if (rx_hold > 0) begin
        rsp_stall <= 1'b1;
        rx_hold--;
      end else if (rx_wait > 0) begin
        rsp_stall <= 1'b1;
        rx_wait--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    blst_pkg::blst_req_t        item;
    int                         style;
    int                         n;
    int                         full_extra;
    int                         sel;
    logic [blst_pkg::POS_W-1:0] in_pos;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DIR_N; k++) begin
      item.req_type   = DIRECTED[k].op;
      item.position   = DIRECTED[k].pos;
      item.item_value = DIRECTED[k].val;
      send_request(item, DIRECTED[k].typed,
                   blst_pkg::blst_rsp_t'{read_value: DIRECTED[k].rd,
                                         status: DIRECTED[k].st,
                                         element_count: DIRECTED[k].cnt});
    end

    for (int phase = 0; phase < 12; phase++) begin
      tx_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
      style   = (phase == 6) ? STYLE_FILL : STYLE_MIX;
      if (phase == 3) begin
        // back the core up while requests keep coming
        hold_requests <= hold_requests + 1;
        tx_mode = IDLE_NONE;
      end
      if (phase == 8) begin
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      n = 0;
      full_extra = 0;
      while ((style == STYLE_MIX) ? (n < 100) : (full_extra < 24)) begin
        item.position   = $urandom_range(0, 255);
        item.item_value = draw_value();
        in_pos = (shadow_count > 0) ?
                 blst_pkg::POS_W'($urandom_range(0, shadow_count - 1)) :
                 blst_pkg::POS_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (style == STYLE_FILL) begin
          if (shadow_count < LIST_CAP) begin
            item.req_type = (sel < 90) ? blst_pkg::REQ_APPEND :
                            ((sel < 95) ? blst_pkg::REQ_READ : blst_pkg::REQ_WRITE);
            if (sel >= 90) item.position = in_pos;
          end else begin
            // full: appends bounce, every position is legal
            full_extra++;
            item.req_type = (sel < 40) ? blst_pkg::REQ_APPEND :
                            ((sel < 70) ? blst_pkg::REQ_READ : blst_pkg::REQ_WRITE);
          end
        end else if (sel < 30) begin
          item.req_type = blst_pkg::REQ_APPEND;
        end else if (sel < 45) begin
          item.req_type = blst_pkg::REQ_REMOVE;
          sel = $urandom_range(0, 9);
          if (sel >= 6 && sel < 9 && shadow_count > 0)
            item.item_value = shadow_elems[$urandom_range(0, shadow_count - 1)];
          else if (sel == 9)
            item.item_value = $urandom;
        end else begin
          item.req_type = (sel < 75) ? blst_pkg::REQ_READ : blst_pkg::REQ_WRITE;
          if ($urandom_range(0, 3) != 0) item.position = in_pos;
        end
        send_request(item, 1'b0, '0);
        n++;
      end
    end

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/blst_pkg.sv
rtl/blst_cell.sv
rtl/blst_chain.sv
rtl/bounded_list_store_core.sv
verif/tb_bounded_list_store_core.sv
